// File: rtl/ttn_pkg.sv
// Shared types, constants and lookup functions of the title text normalizer.
`default_nettype none

package ttn_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5a;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7a;
  localparam logic [7:0] ChNone    = 8'h00;
  localparam logic [7:0] CaseShift = 8'h20;
  localparam logic [7:0] LeadC3    = 8'hc3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } ttn_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_text;
  } ttn_out_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_AND,
    KIND_MARK
  } ttn_kind_e;

  typedef struct packed {
    logic       space;
    ttn_kind_e  kind;
    logic [7:0] ch;
    logic       eot;
  } ttn_cmd_t;

  function automatic logic [7:0] fold_c3(input logic [5:0] idx);
    logic [7:0] f;
    unique case (idx[4:0])
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: f = "a";
      5'd7:                               f = "c";
      5'd8, 5'd9, 5'd10, 5'd11:           f = "e";
      5'd12, 5'd13, 5'd14, 5'd15:         f = "i";
      5'd17:                              f = "n";
      5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
      5'd24:                              f = "o";
      5'd25, 5'd26, 5'd27, 5'd28:         f = "u";
      5'd29:                              f = "y";
      default:                            f = ChNone;
    endcase
    if (idx == 6'd63) begin
      f = "y";
    end
    return f;
  endfunction

  function automatic logic [7:0] and_char(input logic [1:0] k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = "a";
      2'd1:    c = "n";
      default: c = "d";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ttn_front.sv
// Front end: decodes each byte, tracks word and UTF-8 state, issues at most one command per byte.
`default_nettype none

module ttn_front
  import ttn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire ttn_in_t  item_i,
  output logic          cmd_valid_o,
  output ttn_cmd_t      cmd_o
);

  logic       word_open_q, word_open_d;
  logic       space_pending_q, space_pending_d;
  logic       lead_held_q, lead_held_d;
  logic [7:0] held_lead_q, held_lead_d;
  logic       skipping_q, skipping_d;

  logic [7:0] b;
  logic       is_cont;
  logic       consumed;
  logic [7:0] fold_ch;
  ttn_cmd_t   cmd;

  assign b       = item_i.in_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign fold_ch = (held_lead_q == LeadC3) ? fold_c3(b[5:0]) : ChNone;

  always_comb begin
    word_open_d     = word_open_q;
    space_pending_d = space_pending_q;
    lead_held_d     = lead_held_q;
    held_lead_d     = held_lead_q;
    skipping_d      = skipping_q;
    consumed        = 1'b0;
    cmd.space       = 1'b0;
    cmd.kind        = KIND_NONE;
    cmd.ch          = ChNone;
    cmd.eot         = item_i.last_byte;

    if (lead_held_q) begin
      lead_held_d = 1'b0;
      if (is_cont) begin
        consumed = 1'b1;
        if (fold_ch != ChNone) begin
          cmd.space       = space_pending_d && word_open_d;
          space_pending_d = 1'b0;
          cmd.kind        = KIND_CHAR;
          cmd.ch          = fold_ch;
          word_open_d     = 1'b1;
        end else if (word_open_d) begin
          space_pending_d = 1'b1;
        end
      end else if (word_open_d) begin
        space_pending_d = 1'b1;
      end
    end else if (skipping_q) begin
      if (is_cont) begin
        consumed = 1'b1;
      end else begin
        skipping_d = 1'b0;
      end
    end

    if (!consumed) begin
      if (b == ChAmp) begin
        if (word_open_d) begin
          space_pending_d = 1'b1;
        end
        cmd.space       = space_pending_d && word_open_d;
        cmd.kind        = KIND_AND;
        word_open_d     = 1'b1;
        space_pending_d = 1'b1;
      end else if (!b[7]) begin
        if (b >= ChUpperA && b <= ChUpperZ) begin
          cmd.space       = space_pending_d && word_open_d;
          space_pending_d = 1'b0;
          cmd.kind        = KIND_CHAR;
          cmd.ch          = b + CaseShift;
          word_open_d     = 1'b1;
        end else if ((b >= ChLowerA && b <= ChLowerZ) || (b >= ChDigit0 && b <= ChDigit9)) begin
          cmd.space       = space_pending_d && word_open_d;
          space_pending_d = 1'b0;
          cmd.kind        = KIND_CHAR;
          cmd.ch          = b;
          word_open_d     = 1'b1;
        end else if (word_open_d) begin
          space_pending_d = 1'b1;
        end
      end else if (b[7:5] == 3'b110) begin
        lead_held_d = 1'b1;
        held_lead_d = b;
      end else begin
        if (word_open_d) begin
          space_pending_d = 1'b1;
        end
        skipping_d = 1'b1;
      end
    end

    if (item_i.last_byte) begin
      if (cmd.kind == KIND_NONE) begin
        cmd.kind = KIND_MARK;
      end
      word_open_d     = 1'b0;
      space_pending_d = 1'b0;
      lead_held_d     = 1'b0;
      held_lead_d     = ChNone;
      skipping_d      = 1'b0;
    end
  end

  assign cmd_valid_o = valid_i && (cmd.kind != KIND_NONE);
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_open_q     <= 1'b0;
      space_pending_q <= 1'b0;
      lead_held_q     <= 1'b0;
      held_lead_q     <= ChNone;
      skipping_q      <= 1'b0;
    end else if (valid_i) begin
      word_open_q     <= word_open_d;
      space_pending_q <= space_pending_d;
      lead_held_q     <= lead_held_d;
      held_lead_q     <= held_lead_d;
      skipping_q      <= skipping_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttn_queue.sv
// Command queue between the front end and the output sequencer.
`default_nettype none

module ttn_queue
  import ttn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire ttn_cmd_t data_i,
  input  wire logic     pop_i,
  output ttn_cmd_t      data_o,
  output logic          empty_o,
  output logic          full_o
);

  ttn_cmd_t               mem_q [QDepth];
  logic     [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic     [QCntW-1:0]   count_q;
  logic                   do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCntW'(QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ttn_back.sv
// Back end: expands each command into output characters, one request per cycle while the reader pops.
`default_nettype none

module ttn_back
  import ttn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  wire ttn_cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          empty_o,
  input  wire logic     pop_i,
  output ttn_out_t      result_o
);

  logic       cur_valid_q, cur_valid_d;
  ttn_cmd_t   cur_q, cur_d;
  logic [1:0] step_q, step_d;
  logic [1:0] last_step;
  logic [1:0] word_idx;
  logic       at_last;
  logic       advance;

  always_comb begin
    unique case (cur_q.kind)
      KIND_AND: last_step = 2'd2 + {1'b0, cur_q.space};
      KIND_CHAR: last_step = {1'b0, cur_q.space};
      default:  last_step = 2'd0;
    endcase
  end

  assign word_idx = step_q - {1'b0, cur_q.space};
  assign at_last  = (step_q == last_step);
  assign advance  = !cur_valid_q || (pop_i && at_last);
  assign q_pop_o  = advance && !q_empty_i;
  assign empty_o  = !cur_valid_q;

  always_comb begin
    result_o.char_valid  = 1'b1;
    result_o.end_of_text = cur_q.eot && at_last;
    if (cur_q.space && step_q == 2'd0) begin
      result_o.out_char = ChSpace;
    end else begin
      unique case (cur_q.kind)
        KIND_AND:  result_o.out_char = and_char(word_idx);
        KIND_CHAR: result_o.out_char = cur_q.ch;
        default: begin
          result_o.out_char   = ChNone;
          result_o.char_valid = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    step_d      = step_q;
    if (advance) begin
      cur_valid_d = !q_empty_i;
      cur_d       = q_data_i;
      step_d      = 2'd0;
    end else if (pop_i) begin
      step_d = step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

// File: rtl/title_text_normalizer_unit.sv
// Top level of the title text normalizer: front end, command queue and output sequencer.
`default_nettype none

// Takes one title byte per cycle while full is low and folds it to lowercase ASCII words
// separated by single spaces. Each byte is decoded in the cycle it is pushed and leaves at
// most one command in a four-entry queue; the output sequencer turns a command into one
// to four result requests, one per cycle while pop is high, from its output register.
// A plain character gives one request, a character after a pending space two, and '&'
// up to four, so sustained rate is one byte per cycle on ordinary text while pop stays
// high; the queue absorbs the longer '&' expansions, and full rises only once four
// commands wait in the queue; a result passes a queue entry, then the output register.

module title_text_normalizer_unit
  import ttn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire ttn_in_t  item_i,
  output logic          empty,
  input  wire logic     pop,
  output ttn_out_t      result_o
);

  logic     accept;
  logic     cmd_valid;
  ttn_cmd_t cmd;
  ttn_cmd_t q_data;
  logic     q_empty;
  logic     q_pop;

  assign accept = push && !full;

  ttn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  ttn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .data_i  (cmd),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .full_o  (full)
  );

  ttn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire
